[hw/rtl/qes_pkg.sv]
// qes_pkg: shared widths and types for the quantization error statistics unit
// used by every module under hw/rtl; depends on nothing

package qes_pkg;

   localparam int TEST_W = 16;
   localparam int REF_W = 24;
   localparam int POS_W = 24;
   localparam int CNT_OUT_W = 24;
   localparam int EXC_W = 24;
   localparam int SUM_W = 49;
   localparam int SQ_W = 63;
   localparam int SD_W = 64;

   localparam int REQ_DATA_W = 64;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 520;

   localparam logic [EXC_W-1:0] EXC_MAX = '1;

   typedef struct packed {
      logic clipped;
      logic restart;
   } flags_type;

   typedef struct packed {
      logic hit;
      logic [EXC_W-1:0] value;
      logic [POS_W-1:0] position;
   } excess_type;

endpackage

[hw/rtl/qes_front.sv]
// qes_front: forms delta, s and the clamped excess error of one point, registered
// depends on qes_pkg

module qes_front import qes_pkg::*; #(
   parameter int REF_FRAC_BITS = 8,
   parameter int DW = 25
) (
   input  logic clock,
   input  logic load,
   input  logic signed [TEST_W-1:0] test_value,
   input  logic signed [REF_W-1:0] ref_value,
   input  logic [POS_W-1:0] position,
   input  flags_type flags,
   output logic signed [DW-1:0] delta,
   output logic signed [DW-1:0] sum_s,
   output excess_type excess,
   output flags_type flags_out
);

   localparam int FW = (REF_FRAC_BITS > 0) ? REF_FRAC_BITS : 1;
   localparam logic [FW-1:0] FRAC_MASK = FW'((1 << REF_FRAC_BITS) - 1);
   localparam logic [FW:0] ONE = (FW+1)'(1 << REF_FRAC_BITS);
   localparam logic [DW:0] EXC_LIM = (DW+1)'(EXC_MAX);

   logic signed [DW-1:0] tfix;
   logic signed [DW-1:0] refx;
   logic signed [DW-1:0] delta_in;
   logic signed [DW-1:0] sum_s_in;
   logic signed [REF_W:0] refe;
   logic [REF_W:0] aref;
   logic [FW-1:0] frac;
   logic [FW:0] frac2;
   logic [FW:0] rerr;
   logic [DW-1:0] absd;
   logic signed [DW:0] exc_diff;
   excess_type excess_in;

   logic signed [DW-1:0] delta_ff;
   logic signed [DW-1:0] sum_s_ff;
   excess_type excess_ff;
   flags_type flags_ff;

   assign tfix = DW'(test_value) <<< REF_FRAC_BITS;
   assign refx = DW'(ref_value);
   assign delta_in = tfix - refx;
   assign sum_s_in = tfix + refx;

   // distance of the reference to its nearest integer, ties toward zero
   assign refe = (REF_W+1)'(ref_value);
   assign aref = refe[REF_W] ? unsigned'(-refe) : unsigned'(refe);
   assign frac = aref[FW-1:0] & FRAC_MASK;
   assign frac2 = {frac, 1'b0};
   assign rerr = (frac2 > ONE) ? (ONE - {1'b0, frac}) : {1'b0, frac};

   assign absd = delta_in[DW-1] ? unsigned'(-delta_in) : unsigned'(delta_in);
   assign exc_diff = $signed({1'b0, absd}) - $signed((DW+1)'(rerr));

   always_comb begin
      excess_in.hit = !exc_diff[DW] && (exc_diff != '0);
      excess_in.value = (unsigned'(exc_diff) > EXC_LIM) ? EXC_MAX : exc_diff[EXC_W-1:0];
      excess_in.position = position;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         delta_ff <= delta_in;
         sum_s_ff <= sum_s_in;
         excess_ff <= excess_in;
         flags_ff <= flags;
      end
   end

   assign delta = delta_ff;
   assign sum_s = sum_s_ff;
   assign excess = excess_ff;
   assign flags_out = flags_ff;

endmodule

[hw/rtl/qes_mult.sv]
// qes_mult: squares of delta and s and their cross product, registered
// depends on qes_pkg

module qes_mult import qes_pkg::*; #(
   parameter int DW = 25
) (
   input  logic clock,
   input  logic load,
   input  logic signed [DW-1:0] delta,
   input  logic signed [DW-1:0] sum_s,
   input  excess_type excess,
   input  flags_type flags,
   output logic signed [DW-1:0] delta_out,
   output logic signed [DW-1:0] sum_s_out,
   output logic [2*DW-1:0] delta_sq,
   output logic [2*DW-1:0] s_sq,
   output logic signed [2*DW-1:0] s_times_d,
   output excess_type excess_out,
   output flags_type flags_out
);

   logic signed [2*DW-1:0] dsq_p;
   logic signed [2*DW-1:0] ssq_p;
   logic signed [2*DW-1:0] sd_p;

   logic signed [DW-1:0] delta_ff;
   logic signed [DW-1:0] sum_s_ff;
   logic [2*DW-1:0] dsq_ff;
   logic [2*DW-1:0] ssq_ff;
   logic signed [2*DW-1:0] sd_ff;
   excess_type excess_ff;
   flags_type flags_ff;

   assign dsq_p = (2*DW)'(delta) * (2*DW)'(delta);
   assign ssq_p = (2*DW)'(sum_s) * (2*DW)'(sum_s);
   assign sd_p = (2*DW)'(sum_s) * (2*DW)'(delta);

   always_ff @(posedge clock) begin
      if (load) begin
         delta_ff <= delta;
         sum_s_ff <= sum_s;
         dsq_ff <= unsigned'(dsq_p);
         ssq_ff <= unsigned'(ssq_p);
         sd_ff <= sd_p;
         excess_ff <= excess;
         flags_ff <= flags;
      end
   end

   assign delta_out = delta_ff;
   assign sum_s_out = sum_s_ff;
   assign delta_sq = dsq_ff;
   assign s_sq = ssq_ff;
   assign s_times_d = sd_ff;
   assign excess_out = excess_ff;
   assign flags_out = flags_ff;

endmodule

[hw/rtl/qes_accum.sv]
// qes_accum: saturating accumulators and maximum tracking, doubling as the result register
// depends on qes_pkg

module qes_accum import qes_pkg::*; #(
   parameter int DW = 25,
   parameter int COUNT_BITS = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic update,
   input  logic signed [DW-1:0] delta,
   input  logic signed [DW-1:0] sum_s,
   input  logic [2*DW-1:0] delta_sq,
   input  logic [2*DW-1:0] s_sq,
   input  logic signed [2*DW-1:0] s_times_d,
   input  excess_type excess,
   input  flags_type flags,
   output logic [CNT_OUT_W-1:0] point_count,
   output logic signed [SUM_W-1:0] delta_sum,
   output logic [SQ_W-1:0] delta_square_sum,
   output logic [CNT_OUT_W-1:0] excess_count,
   output logic [EXC_W-1:0] max_excess,
   output logic [POS_W-1:0] max_excess_position,
   output logic [CNT_OUT_W-1:0] unclipped_count,
   output logic signed [SUM_W-1:0] sum_s_out,
   output logic signed [SUM_W-1:0] sum_d,
   output logic [SQ_W-1:0] sum_s_squared,
   output logic [SQ_W-1:0] sum_d_squared,
   output logic signed [SD_W-1:0] sum_s_times_d
);

   function automatic logic [COUNT_BITS-1:0] cnt_inc(input logic [COUNT_BITS-1:0] c);
      return (c == '1) ? c : c + 1'b1;
   endfunction

   function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [SUM_W-1:0] b);
      logic signed [SUM_W:0] r;
      r = (SUM_W+1)'(a) + (SUM_W+1)'(b);
      if (r[SUM_W] != r[SUM_W-1]) begin
         return r[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end
      return r[SUM_W-1:0];
   endfunction

   function automatic logic [SQ_W-1:0] sat_sq(input logic [SQ_W-1:0] a,
                                             input logic [SQ_W-1:0] b);
      logic [SQ_W:0] r;
      r = (SQ_W+1)'(a) + (SQ_W+1)'(b);
      return r[SQ_W] ? '1 : r[SQ_W-1:0];
   endfunction

   function automatic logic signed [SD_W-1:0] sat_sd(input logic signed [SD_W-1:0] a,
                                                    input logic signed [SD_W-1:0] b);
      logic signed [SD_W:0] r;
      r = (SD_W+1)'(a) + (SD_W+1)'(b);
      if (r[SD_W] != r[SD_W-1]) begin
         return r[SD_W] ? {1'b1, {(SD_W-1){1'b0}}} : {1'b0, {(SD_W-1){1'b1}}};
      end
      return r[SD_W-1:0];
   endfunction

   logic [COUNT_BITS-1:0] count_ff, count_in, count_base;
   logic signed [SUM_W-1:0] delta_acc_ff, delta_acc_in, delta_acc_base;
   logic [SQ_W-1:0] delta_sq_acc_ff, delta_sq_acc_in, delta_sq_acc_base;
   logic [COUNT_BITS-1:0] exc_count_ff, exc_count_in, exc_count_base;
   logic [EXC_W-1:0] max_exc_ff, max_exc_in, max_exc_base;
   logic [POS_W-1:0] max_pos_ff, max_pos_in, max_pos_base;
   logic [COUNT_BITS-1:0] unclipped_ff, unclipped_in, unclipped_base;
   logic signed [SUM_W-1:0] s_acc_ff, s_acc_in, s_acc_base;
   logic signed [SUM_W-1:0] d_acc_ff, d_acc_in, d_acc_base;
   logic [SQ_W-1:0] s_sq_acc_ff, s_sq_acc_in, s_sq_acc_base;
   logic [SQ_W-1:0] d_sq_acc_ff, d_sq_acc_in, d_sq_acc_base;
   logic signed [SD_W-1:0] sd_acc_ff, sd_acc_in, sd_acc_base;

   logic signed [SUM_W-1:0] delta_x;
   logic signed [SUM_W-1:0] s_x;
   logic [SQ_W-1:0] dsq_x;
   logic [SQ_W-1:0] ssq_x;
   logic signed [SD_W-1:0] sd_x;

   assign delta_x = SUM_W'(delta);
   assign s_x = SUM_W'(sum_s);
   assign dsq_x = SQ_W'(delta_sq);
   assign ssq_x = SQ_W'(s_sq);
   assign sd_x = SD_W'(s_times_d);

   always_comb begin
      // restart clears the totals before this point is added
      count_base = flags.restart ? '0 : count_ff;
      delta_acc_base = flags.restart ? '0 : delta_acc_ff;
      delta_sq_acc_base = flags.restart ? '0 : delta_sq_acc_ff;
      exc_count_base = flags.restart ? '0 : exc_count_ff;
      max_exc_base = flags.restart ? '0 : max_exc_ff;
      max_pos_base = flags.restart ? '0 : max_pos_ff;
      unclipped_base = flags.restart ? '0 : unclipped_ff;
      s_acc_base = flags.restart ? '0 : s_acc_ff;
      d_acc_base = flags.restart ? '0 : d_acc_ff;
      s_sq_acc_base = flags.restart ? '0 : s_sq_acc_ff;
      d_sq_acc_base = flags.restart ? '0 : d_sq_acc_ff;
      sd_acc_base = flags.restart ? '0 : sd_acc_ff;

      count_in = cnt_inc(count_base);
      delta_acc_in = sat_sum(delta_acc_base, delta_x);
      delta_sq_acc_in = sat_sq(delta_sq_acc_base, dsq_x);

      exc_count_in = exc_count_base;
      max_exc_in = max_exc_base;
      max_pos_in = max_pos_base;
      if (excess.hit) begin
         exc_count_in = cnt_inc(exc_count_base);
         // strictly greater, so a tie keeps the earlier position
         if (excess.value > max_exc_base) begin
            max_exc_in = excess.value;
            max_pos_in = excess.position;
         end
      end

      unclipped_in = unclipped_base;
      s_acc_in = s_acc_base;
      d_acc_in = d_acc_base;
      s_sq_acc_in = s_sq_acc_base;
      d_sq_acc_in = d_sq_acc_base;
      sd_acc_in = sd_acc_base;
      if (!flags.clipped) begin
         unclipped_in = cnt_inc(unclipped_base);
         s_acc_in = sat_sum(s_acc_base, s_x);
         d_acc_in = sat_sum(d_acc_base, delta_x);
         s_sq_acc_in = sat_sq(s_sq_acc_base, ssq_x);
         d_sq_acc_in = sat_sq(d_sq_acc_base, dsq_x);
         sd_acc_in = sat_sd(sd_acc_base, sd_x);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         delta_acc_ff <= '0;
         delta_sq_acc_ff <= '0;
         exc_count_ff <= '0;
         max_exc_ff <= '0;
         max_pos_ff <= '0;
         unclipped_ff <= '0;
         s_acc_ff <= '0;
         d_acc_ff <= '0;
         s_sq_acc_ff <= '0;
         d_sq_acc_ff <= '0;
         sd_acc_ff <= '0;
      end else if (update) begin
         count_ff <= count_in;
         delta_acc_ff <= delta_acc_in;
         delta_sq_acc_ff <= delta_sq_acc_in;
         exc_count_ff <= exc_count_in;
         max_exc_ff <= max_exc_in;
         max_pos_ff <= max_pos_in;
         unclipped_ff <= unclipped_in;
         s_acc_ff <= s_acc_in;
         d_acc_ff <= d_acc_in;
         s_sq_acc_ff <= s_sq_acc_in;
         d_sq_acc_ff <= d_sq_acc_in;
         sd_acc_ff <= sd_acc_in;
      end
   end

   assign point_count = CNT_OUT_W'(count_ff);
   assign delta_sum = delta_acc_ff;
   assign delta_square_sum = delta_sq_acc_ff;
   assign excess_count = CNT_OUT_W'(exc_count_ff);
   assign max_excess = max_exc_ff;
   assign max_excess_position = max_pos_ff;
   assign unclipped_count = CNT_OUT_W'(unclipped_ff);
   assign sum_s_out = s_acc_ff;
   assign sum_d = d_acc_ff;
   assign sum_s_squared = s_sq_acc_ff;
   assign sum_d_squared = d_sq_acc_ff;
   assign sum_s_times_d = sd_acc_ff;

endmodule

[hw/rtl/quantization_error_stats_unit.sv]
// quantization_error_stats_unit: top level, input register, stage control and result packing
// depends on qes_pkg, qes_front, qes_mult and qes_accum
//
//   channel  | ports                        | transaction
//   ---------+------------------------------+------------------------------------------
//   request  | req_tvalid/tready/tdata/tuser| one point: test, ref, position, flags
//   response | rsp_tvalid/tready/tdata      | all totals after that point is added
//
// one point per cycle sustained while the response is not stalled; the registered accumulate loop sets that figure
// the result passes through the input, front, multiply and accumulate registers in turn
// reset clears the stage valid bits and every accumulator and holds req_tready low
// a stalled response holds in the accumulators while empty stages keep accepting

module quantization_error_stats_unit import qes_pkg::*; #(
   parameter int REF_FRAC_BITS = 8,
   parameter int COUNT_BITS = 24
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // test_value, ref_value, position
   input  logic [REQ_USER_W-1:0] req_tuser,   // is_clipped, restart
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // point_count, delta_sum, delta_square_sum, excess_count, max_excess,
   // max_excess_position, unclipped_count, sum_s, sum_d, sum_s_squared,
   // sum_d_squared, sum_s_times_d
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int TW = TEST_W + REF_FRAC_BITS;
   localparam int DW = ((TW > REF_W) ? TW : REF_W) + 1;

   logic v1_ff, v1_in;
   logic v2_ff, v2_in;
   logic v3_ff, v3_in;
   logic out_valid_ff, out_valid_in;
   logic accept, ld2, ld3, adv_out;

   logic signed [TEST_W-1:0] test_ff;
   logic signed [REF_W-1:0] ref_ff;
   logic [POS_W-1:0] pos_ff;
   flags_type flags1_ff;
   flags_type req_flags;

   logic signed [DW-1:0] delta2, sum_s2;
   excess_type excess2;
   flags_type flags2;

   logic signed [DW-1:0] delta3, sum_s3;
   logic [2*DW-1:0] dsq3, ssq3;
   logic signed [2*DW-1:0] sd3;
   excess_type excess3;
   flags_type flags3;

   logic [CNT_OUT_W-1:0] point_count, excess_count, unclipped_count;
   logic signed [SUM_W-1:0] delta_sum, sum_s, sum_d;
   logic [SQ_W-1:0] delta_square_sum, sum_s_squared, sum_d_squared;
   logic [EXC_W-1:0] max_excess;
   logic [POS_W-1:0] max_excess_position;
   logic signed [SD_W-1:0] sum_s_times_d;

   assign adv_out = v3_ff && (!out_valid_ff || rsp_tready);
   assign ld3 = v2_ff && (!v3_ff || adv_out);
   assign ld2 = v1_ff && (!v2_ff || ld3);
   assign req_tready = !reset && (!v1_ff || ld2);
   assign accept = req_tvalid && req_tready;

   always_comb begin
      v1_in = accept ? 1'b1 : (ld2 ? 1'b0 : v1_ff);
      v2_in = ld2 ? 1'b1 : (ld3 ? 1'b0 : v2_ff);
      v3_in = ld3 ? 1'b1 : (adv_out ? 1'b0 : v3_ff);
      out_valid_in = adv_out ? 1'b1 : ((rsp_tready) ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_comb begin
      req_flags.clipped = req_tuser[0];
      req_flags.restart = req_tuser[1];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         test_ff <= signed'(req_tdata[TEST_W-1:0]);
         ref_ff <= signed'(req_tdata[TEST_W+REF_W-1:TEST_W]);
         pos_ff <= req_tdata[TEST_W+REF_W+POS_W-1:TEST_W+REF_W];
         flags1_ff <= req_flags;
      end
   end

   qes_front #(
      .REF_FRAC_BITS(REF_FRAC_BITS),
      .DW(DW)
   ) u_front (
      .clock(clock),
      .load(ld2),
      .test_value(test_ff),
      .ref_value(ref_ff),
      .position(pos_ff),
      .flags(flags1_ff),
      .delta(delta2),
      .sum_s(sum_s2),
      .excess(excess2),
      .flags_out(flags2)
   );

   qes_mult #(
      .DW(DW)
   ) u_mult (
      .clock(clock),
      .load(ld3),
      .delta(delta2),
      .sum_s(sum_s2),
      .excess(excess2),
      .flags(flags2),
      .delta_out(delta3),
      .sum_s_out(sum_s3),
      .delta_sq(dsq3),
      .s_sq(ssq3),
      .s_times_d(sd3),
      .excess_out(excess3),
      .flags_out(flags3)
   );

   qes_accum #(
      .DW(DW),
      .COUNT_BITS(COUNT_BITS)
   ) u_accum (
      .clock(clock),
      .reset(reset),
      .update(adv_out),
      .delta(delta3),
      .sum_s(sum_s3),
      .delta_sq(dsq3),
      .s_sq(ssq3),
      .s_times_d(sd3),
      .excess(excess3),
      .flags(flags3),
      .point_count(point_count),
      .delta_sum(delta_sum),
      .delta_square_sum(delta_square_sum),
      .excess_count(excess_count),
      .max_excess(max_excess),
      .max_excess_position(max_excess_position),
      .unclipped_count(unclipped_count),
      .sum_s_out(sum_s),
      .sum_d(sum_d),
      .sum_s_squared(sum_s_squared),
      .sum_d_squared(sum_d_squared),
      .sum_s_times_d(sum_s_times_d)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {sum_s_times_d, sum_d_squared, sum_s_squared, sum_d, sum_s,
                       unclipped_count, max_excess_position, max_excess, excess_count,
                       delta_square_sum, delta_sum, point_count};

endmodule
